>>> sv/clipped_gouraud_span_walker_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the clipped Gouraud span walker
// Immediate-consequence and next-cycle implication checks on aclk/aresetn.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_GOURAUD_SPAN_WALKER_ASSERT_SVH
`define CLIPPED_GOURAUD_SPAN_WALKER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CGSW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("span walker check failed");

// antecedent implies consequent in the following cycle
`define CGSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("span walker check failed");

`endif

>>> sv/cgsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped Gouraud span walker package
// Constants, register indexes and sequencer state type.
// ----------------------------------------------------------------------------
package cgsw_pkg;

    localparam int COLOR_FRAC_BITS = 16;
    localparam int MAX_SPAN        = 64;
    localparam int CNT_W           = $clog2(MAX_SPAN + 1);
    localparam int COORD_W         = 16;
    localparam int COLOR_W         = 32;
    localparam int PIX_COLOR_W     = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int IN_DATA_W       = 112;
    localparam int OUT_DATA_W      = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLIP_ENABLE = 3'd0,
        REG_CLIP_LEFT   = 3'd1,
        REG_CLIP_RIGHT  = 3'd2,
        REG_CLIP_TOP    = 3'd3,
        REG_CLIP_BOTTOM = 3'd4,
        REG_ORIGIN_X    = 3'd5,
        REG_ORIGIN_Y    = 3'd6,
        REG_UNUSED      = 3'd7
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLIP  = 5'b00010,
        S_MUL   = 5'b00100,
        S_SETUP = 5'b01000,
        S_WALK  = 5'b10000
    } state_t;

endpackage

>>> sv/clipped_gouraud_span_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped Gouraud span walker
// Offsets, clips and walks one span, one shaded pixel per unstalled cycle.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per span (row, start and end column, end
// exclusive going up, start exclusive going down, direction in s_tuser,
// fixed-point start colour and step). Output m_*: one item per pixel,
// m_tlast on the last pixel, m_tuser on each pixel of a span cut at 64.
// Configuration channel cfg_*: register index and data, always ready; write
// only while no span is in progress.
// Operation: a span passes clip, multiply and setup steps in turn, then the
// walk loads one pixel per cycle into the output register while m_tready
// does not stall it. The single 17x32 multiplier corrects the colour of a
// clipped start, and the colour adder is shared between that correction
// and the per-pixel step. s_tready is high only while no span is held.
// Stalls on m_tready freeze the walk with the pending pixel held in the
// output register.
// Reset (aresetn low, synchronous) clears the walk, drops m_tvalid and
// restores the clip window 0..1023 x 0..767, clipping off, zero origin.
// ----------------------------------------------------------------------------
module clipped_gouraud_span_walker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // row, x_start, x_end, color_start, color_step
    input  logic [cgsw_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [cgsw_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tlast,
    // truncated
    output logic                             m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cgsw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cgsw_pkg::COORD_W-1:0]     cfg_data
);
    import cgsw_pkg::*;

    state_t state_reg, state_next;

    logic                       clip_enable_reg;
    logic signed [COORD_W-1:0]  clip_left_reg, clip_right_reg;
    logic signed [COORD_W-1:0]  clip_top_reg, clip_bottom_reg;
    logic signed [COORD_W-1:0]  origin_x_reg, origin_y_reg;

    logic                       down_reg, down_next;
    logic signed [COORD_W:0]    y_reg, y_next;
    logic signed [COORD_W:0]    xs_reg, xs_next;
    logic signed [COORD_W:0]    xe_reg, xe_next;
    logic [COLOR_W-1:0]         col_reg, col_next;
    logic [COLOR_W-1:0]         step_reg, step_next;
    logic [COORD_W:0]           skip_reg, skip_next;
    logic                       row_ok_reg, row_ok_next;
    logic [COLOR_W-1:0]         prod_reg, prod_next;
    logic                       trunc_reg, trunc_next;

    logic [COORD_W-1:0]         cur_x_reg, cur_x_next;
    logic [COLOR_W-1:0]         cur_color_reg, cur_color_next;
    logic [CNT_W-1:0]           pixels_left_reg, pixels_left_next;

    logic                       m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]      m_data_reg, m_data_next;
    logic                       m_last_reg, m_last_next;
    logic                       m_user_reg, m_user_next;

    logic signed [COORD_W:0]    cl_ext, cr1_ext, ct_ext, cb_ext;
    logic signed [COORD_W+1:0]  diff_skip;
    logic signed [COORD_W+1:0]  count;
    logic [COLOR_W-1:0]         add_a, add_b, add_sum;
    logic                       add_sub;
    logic [COLOR_W+COORD_W:0]   prod_full;
    logic                       load_pix;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;
    assign m_tuser   = m_user_reg;

    assign cl_ext  = {clip_left_reg[COORD_W-1], clip_left_reg};
    assign cr1_ext = {clip_right_reg[COORD_W-1], clip_right_reg} + 17'sd1;
    assign ct_ext  = {clip_top_reg[COORD_W-1], clip_top_reg};
    assign cb_ext  = {clip_bottom_reg[COORD_W-1], clip_bottom_reg};

    assign prod_full = skip_reg * step_reg;
    assign count     = down_reg ? ({xs_reg[COORD_W], xs_reg} - {xe_reg[COORD_W], xe_reg})
                                : ({xe_reg[COORD_W], xe_reg} - {xs_reg[COORD_W], xs_reg});
    assign load_pix  = !m_valid_reg || m_tready;

    // shared colour adder: start correction in setup, per-pixel step in walk
    always_comb begin
        if (state_reg == S_SETUP) begin
            add_a = col_reg;
            add_b = prod_reg;
        end else begin
            add_a = cur_color_reg;
            add_b = step_reg;
        end
        add_sub = down_reg;
        add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
    end

    always_comb begin
        state_next       = state_reg;
        down_next        = down_reg;
        y_next           = y_reg;
        xs_next          = xs_reg;
        xe_next          = xe_reg;
        col_next         = col_reg;
        step_next        = step_reg;
        skip_next        = skip_reg;
        row_ok_next      = row_ok_reg;
        prod_next        = prod_reg;
        trunc_next       = trunc_reg;
        cur_x_next       = cur_x_reg;
        cur_color_next   = cur_color_reg;
        pixels_left_next = pixels_left_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        m_last_next      = m_last_reg;
        m_user_next      = m_user_reg;
        diff_skip        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    down_next  = s_tuser;
                    y_next     = {s_tdata[15], s_tdata[15:0]}
                               + {origin_y_reg[COORD_W-1], origin_y_reg};
                    xs_next    = {s_tdata[31], s_tdata[31:16]}
                               + {origin_x_reg[COORD_W-1], origin_x_reg};
                    xe_next    = {s_tdata[47], s_tdata[47:32]}
                               + {origin_x_reg[COORD_W-1], origin_x_reg};
                    col_next   = s_tdata[79:48];
                    step_next  = s_tdata[111:80];
                    state_next = S_CLIP;
                end
            end
            S_CLIP: begin
                skip_next   = '0;
                row_ok_next = 1'b1;
                if (clip_enable_reg) begin
                    row_ok_next = !((y_reg < ct_ext) || (y_reg > cb_ext));
                    if (!down_reg) begin
                        if (xs_reg < cl_ext) begin
                            diff_skip = {cl_ext[COORD_W], cl_ext} - {xs_reg[COORD_W], xs_reg};
                            skip_next = diff_skip[COORD_W:0];
                            xs_next   = cl_ext;
                        end
                        if (xe_reg > cr1_ext) begin
                            xe_next = cr1_ext;
                        end
                    end else begin
                        if (xs_reg > cr1_ext) begin
                            diff_skip = {xs_reg[COORD_W], xs_reg} - {cr1_ext[COORD_W], cr1_ext};
                            skip_next = diff_skip[COORD_W:0];
                            xs_next   = cr1_ext;
                        end
                        if (xe_reg < cl_ext) begin
                            xe_next = cl_ext;
                        end
                    end
                end
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = prod_full[COLOR_W-1:0];
                state_next = S_SETUP;
            end
            S_SETUP: begin
                if (row_ok_reg && (count > 18'sd0)) begin
                    cur_x_next     = down_reg ? (xs_reg[COORD_W-1:0] - 16'd1)
                                              : xs_reg[COORD_W-1:0];
                    cur_color_next = add_sum;
                    if (count > MAX_SPAN) begin
                        pixels_left_next = CNT_W'(MAX_SPAN);
                        trunc_next       = 1'b1;
                    end else begin
                        pixels_left_next = count[CNT_W-1:0];
                        trunc_next       = 1'b0;
                    end
                    state_next = S_WALK;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_WALK: begin
                if (load_pix) begin
                    m_valid_next     = 1'b1;
                    m_data_next      = {cur_color_reg[COLOR_FRAC_BITS +: PIX_COLOR_W],
                                        y_reg[COORD_W-1:0], cur_x_reg};
                    m_last_next      = (pixels_left_reg == CNT_W'(1));
                    m_user_next      = trunc_reg;
                    cur_x_next       = down_reg ? (cur_x_reg - 16'd1) : (cur_x_reg + 16'd1);
                    cur_color_next   = add_sum;
                    pixels_left_next = pixels_left_reg - CNT_W'(1);
                    if (pixels_left_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_valid_reg     <= 1'b0;
            pixels_left_reg <= '0;
            cur_x_reg       <= '0;
            cur_color_reg   <= '0;
            clip_enable_reg <= 1'b0;
            clip_left_reg   <= 16'sd0;
            clip_right_reg  <= 16'sd1023;
            clip_top_reg    <= 16'sd0;
            clip_bottom_reg <= 16'sd767;
            origin_x_reg    <= 16'sd0;
            origin_y_reg    <= 16'sd0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            pixels_left_reg <= pixels_left_next;
            cur_x_reg       <= cur_x_next;
            cur_color_reg   <= cur_color_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_CLIP_ENABLE: clip_enable_reg <= cfg_data[0];
                    REG_CLIP_LEFT:   clip_left_reg   <= cfg_data;
                    REG_CLIP_RIGHT:  clip_right_reg  <= cfg_data;
                    REG_CLIP_TOP:    clip_top_reg    <= cfg_data;
                    REG_CLIP_BOTTOM: clip_bottom_reg <= cfg_data;
                    REG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                    REG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                    REG_UNUSED:      clip_enable_reg <= clip_enable_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        down_reg   <= down_next;
        y_reg      <= y_next;
        xs_reg     <= xs_next;
        xe_reg     <= xe_next;
        col_reg    <= col_next;
        step_reg   <= step_next;
        skip_reg   <= skip_next;
        row_ok_reg <= row_ok_next;
        prod_reg   <= prod_next;
        trunc_reg  <= trunc_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

`include "clipped_gouraud_span_walker_assert.svh"

    `CGSW_ASSERT_NEXT(a_accept_to_clip, s_tvalid && s_tready, state_reg == S_CLIP)
    `CGSW_ASSERT_NOW(a_walk_has_pixels, state_reg == S_WALK, pixels_left_reg != '0)
    `CGSW_ASSERT_NEXT(a_last_ends_walk,
        (state_reg == S_WALK) && load_pix && (pixels_left_reg == CNT_W'(1)),
        (state_reg == S_IDLE) && m_tvalid && m_tlast)

endmodule
